// ===== design/fsc_pkg.sv =====
// fsc_pkg: shared types and constants of the forth stack core
// widths, stack and memory sizes, primitive and error codes, item structs
// used by fsc_div and forth_stack_core
`default_nettype none

package fsc_pkg;

	localparam int CELL_BITS    = 32;
	localparam int STACK_DEPTH  = 32;
	localparam int RSTACK_DEPTH = 32;
	localparam int MEM_CELLS    = 1024;
	localparam int SP_BITS      = 6;
	localparam int SIDX_BITS    = $clog2(STACK_DEPTH);
	localparam int RIDX_BITS    = $clog2(RSTACK_DEPTH);
	localparam int MADDR_BITS   = $clog2(MEM_CELLS);
	localparam int FREE_BITS    = 11;
	localparam int DCNT_BITS    = $clog2(CELL_BITS);

	typedef enum logic [4:0] {
		MODE_DUP, MODE_DROP, MODE_SWAP, MODE_OVER, MODE_ROT,
		MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD,
		MODE_TOR, MODE_RFROM, MODE_RFETCH,
		MODE_EQ, MODE_LT, MODE_GT, MODE_ZEQ,
		MODE_FETCH, MODE_STORE, MODE_HERE, MODE_COMMA,
		MODE_LIT, MODE_BRANCH, MODE_ZBRANCH
	} mode_t;

	typedef enum logic [2:0] {
		ERR_OK, ERR_DUNDER, ERR_DOVER, ERR_RUNDER, ERR_ROVER, ERR_DIVZ, ERR_ADDR
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RDB, ST_RDC, ST_EXE, ST_ROT2, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic [4:0]                  mode;
		logic signed [CELL_BITS-1:0] inline_cell;
	} cmd_t;

	typedef struct packed {
		logic signed [CELL_BITS-1:0] top_value;
		logic [SP_BITS-1:0]          data_depth;
		logic [SP_BITS-1:0]          return_depth;
		logic                        take_branch;
		logic                        used_inline;
		logic [2:0]                  error_code;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/forth_stack_core.sv =====
// forth_stack_core: executes one forth primitive per command item
// data and return stacks and the cell memory sit in synchronous rams
// depends on fsc_pkg and fsc_div
//
// cmd channel: cmd_valid/cmd_stall with a cmd_t item (mode, inline_cell).
// rsp channel: rsp_valid/rsp_stall with one rsp_t item per command.
// an item is taken at a rising edge with valid high and stall low.
// sequence: a command is taken, then ram reads in the RDB and RDC states
// fetch the second and third stack cells (the top cell lives in a register),
// the EXE state executes and writes back, and the OUT state loads the result
// register. rot adds the ROT2 state for its second stack write; div and mod
// add the DIV state, which waits for the bit serial divider. cmd_stall
// is high while a command is in work.
// a finished item waits in the result register while the next command is
// taken; the core only holds in its OUT state if rsp_stall still keeps
// the previous item there.
// reset: both stacks empty, here pointer zero, no item pending. stack
// and cell ram contents are undefined until written and need no clearing.
// errors leave all state unchanged and are reported in error_code.
`default_nettype none

module forth_stack_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire fsc_pkg::cmd_t  cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output fsc_pkg::rsp_t       rsp
);
	import fsc_pkg::*;

	state_t state_q, state_d;

	logic [4:0]           mode_q;
	logic [CELL_BITS-1:0] imm_q;
	logic [SP_BITS-1:0]   dp_q, rp_q;
	logic [FREE_BITS-1:0] free_q;
	logic [CELL_BITS-1:0] top_q, b_q;
	logic                 br_q, used_q;
	err_t                 err_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic [CELL_BITS-1:0] ds_mem [STACK_DEPTH];
	logic [CELL_BITS-1:0] rs_mem [RSTACK_DEPTH];
	logic [CELL_BITS-1:0] cm_mem [MEM_CELLS];
	logic [CELL_BITS-1:0] ds_rd_q, rs_rd_q, cm_rd_q;

	logic                 ds_re, rs_re, cm_re;
	logic [SIDX_BITS-1:0] ds_raddr;
	logic                 ds_we, rs_we, cm_we;
	logic [SIDX_BITS-1:0] ds_waddr;
	logic [CELL_BITS-1:0] ds_wdata, cm_wdata;
	logic [MADDR_BITS-1:0] cm_waddr;

	logic [CELL_BITS-1:0] a, c;
	logic [1:0]           need;
	err_t                 err_c;
	logic [CELL_BITS-1:0] ex_top, prod;
	logic [SP_BITS-1:0]   ex_dp, ex_rp;
	logic                 ex_br, ex_used, ex_free_inc, go_rot, go_div;
	logic                 addr_ok, rsp_free;

	logic                 div_busy, div_done;
	logic [CELL_BITS-1:0] div_q, div_r, div_res, mag_a, mag_b;

	assign a    = top_q;
	assign c    = ds_rd_q;
	assign prod = b_q * a;
	assign mag_a = a[CELL_BITS-1] ? (~a + 1'b1) : a;
	assign mag_b = b_q[CELL_BITS-1] ? (~b_q + 1'b1) : b_q;
	assign addr_ok = !a[CELL_BITS-1] && (a < CELL_BITS'(MEM_CELLS));
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// check order: pop underflow, push overflow, divisor, address
	always_comb begin
		need = 2'd0;
		case (mode_q) inside
			MODE_DUP, MODE_DROP, MODE_TOR, MODE_ZEQ, MODE_FETCH, MODE_COMMA,
			MODE_ZBRANCH: need = 2'd1;
			MODE_SWAP, MODE_OVER, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
			MODE_MOD, MODE_EQ, MODE_LT, MODE_GT, MODE_STORE: need = 2'd2;
			MODE_ROT: need = 2'd3;
			default: need = 2'd0;
		endcase
		err_c = ERR_OK;
		if (dp_q < SP_BITS'(need))
			err_c = ERR_DUNDER;
		else if ((mode_q == MODE_RFROM || mode_q == MODE_RFETCH) && rp_q == '0)
			err_c = ERR_RUNDER;
		else if ((mode_q == MODE_DUP || mode_q == MODE_OVER || mode_q == MODE_RFROM ||
				mode_q == MODE_RFETCH || mode_q == MODE_HERE || mode_q == MODE_LIT) &&
				dp_q >= SP_BITS'(STACK_DEPTH))
			err_c = ERR_DOVER;
		else if (mode_q == MODE_TOR && rp_q >= SP_BITS'(RSTACK_DEPTH))
			err_c = ERR_ROVER;
		else if ((mode_q == MODE_DIV || mode_q == MODE_MOD) && a == '0)
			err_c = ERR_DIVZ;
		else if ((mode_q == MODE_FETCH || mode_q == MODE_STORE) && !addr_ok)
			err_c = ERR_ADDR;
		else if (mode_q == MODE_COMMA && free_q >= FREE_BITS'(MEM_CELLS))
			err_c = ERR_ADDR;
	end

	// execute step: new top, pointers and the one write per ram
	always_comb begin
		ex_top = top_q;
		ex_dp = dp_q;
		ex_rp = rp_q;
		ex_br = 1'b0;
		ex_used = 1'b0;
		ex_free_inc = 1'b0;
		go_rot = 1'b0;
		go_div = 1'b0;
		ds_we = 1'b0;
		ds_waddr = dp_q[SIDX_BITS-1:0] - 1'b1;
		ds_wdata = a;
		rs_we = 1'b0;
		cm_we = 1'b0;
		cm_waddr = a[MADDR_BITS-1:0];
		cm_wdata = b_q;
		if (state_q == ST_ROT2) begin
			ds_we = 1'b1;
			ds_waddr = dp_q[SIDX_BITS-1:0] - 2'd3;
			ds_wdata = b_q;
		end else if (state_q == ST_EXE && err_c == ERR_OK) begin
			case (mode_q)
				MODE_DUP: begin
					ds_we = 1'b1;
					ex_dp = dp_q + 1'b1;
				end
				MODE_DROP, MODE_TOR, MODE_COMMA: begin
					ex_dp = dp_q - 1'b1;
					ex_top = (dp_q == SP_BITS'(1)) ? '0 : b_q;
					rs_we = (mode_q == MODE_TOR);
					ex_rp = (mode_q == MODE_TOR) ? rp_q + 1'b1 : rp_q;
					cm_we = (mode_q == MODE_COMMA);
					cm_waddr = free_q[MADDR_BITS-1:0];
					cm_wdata = a;
					ex_free_inc = (mode_q == MODE_COMMA);
				end
				MODE_ZBRANCH: begin
					ex_dp = dp_q - 1'b1;
					ex_top = (dp_q == SP_BITS'(1)) ? '0 : b_q;
					ex_br = (a == '0);
					ex_used = (a != '0);
				end
				MODE_SWAP: begin
					ds_we = 1'b1;
					ds_waddr = dp_q[SIDX_BITS-1:0] - 2'd2;
					ex_top = b_q;
				end
				MODE_OVER: begin
					ds_we = 1'b1;
					ex_dp = dp_q + 1'b1;
					ex_top = b_q;
				end
				MODE_ROT: begin
					ds_we = 1'b1;
					ds_waddr = dp_q[SIDX_BITS-1:0] - 2'd2;
					go_rot = 1'b1;
				end
				MODE_ADD: begin
					ex_dp = dp_q - 1'b1;
					ex_top = b_q + a;
				end
				MODE_SUB: begin
					ex_dp = dp_q - 1'b1;
					ex_top = b_q - a;
				end
				MODE_MUL: begin
					ex_dp = dp_q - 1'b1;
					ex_top = prod;
				end
				MODE_DIV, MODE_MOD: go_div = 1'b1;
				MODE_EQ: begin
					ex_dp = dp_q - 1'b1;
					ex_top = {CELL_BITS{b_q == a}};
				end
				MODE_LT: begin
					ex_dp = dp_q - 1'b1;
					ex_top = {CELL_BITS{$signed(b_q) < $signed(a)}};
				end
				MODE_GT: begin
					ex_dp = dp_q - 1'b1;
					ex_top = {CELL_BITS{$signed(b_q) > $signed(a)}};
				end
				MODE_RFROM, MODE_RFETCH: begin
					ds_we = 1'b1;
					ex_dp = dp_q + 1'b1;
					ex_top = rs_rd_q;
					ex_rp = (mode_q == MODE_RFROM) ? rp_q - 1'b1 : rp_q;
				end
				MODE_ZEQ: ex_top = {CELL_BITS{a == '0}};
				MODE_FETCH: ex_top = cm_rd_q;
				MODE_STORE: begin
					cm_we = 1'b1;
					ex_dp = dp_q - 2'd2;
					ex_top = (dp_q == SP_BITS'(2)) ? '0 : c;
				end
				MODE_HERE: begin
					ds_we = 1'b1;
					ex_dp = dp_q + 1'b1;
					ex_top = CELL_BITS'(free_q);
				end
				MODE_LIT: begin
					ds_we = 1'b1;
					ex_dp = dp_q + 1'b1;
					ex_top = imm_q;
					ex_used = 1'b1;
				end
				MODE_BRANCH: ex_br = 1'b1;
				default: ;
			endcase
		end
	end

	fsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go_div),
		.dividend  (mag_b),
		.divisor   (mag_a),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_comb begin
		if (mode_q == MODE_DIV)
			div_res = (b_q[CELL_BITS-1] != a[CELL_BITS-1]) ? (~div_q + 1'b1) : div_q;
		else
			div_res = b_q[CELL_BITS-1] ? (~div_r + 1'b1) : div_r;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) state_d = ST_RDB;
			ST_RDB:  state_d = ST_RDC;
			ST_RDC:  state_d = ST_EXE;
			ST_EXE: begin
				if (go_rot)      state_d = ST_ROT2;
				else if (go_div) state_d = ST_DIV;
				else             state_d = ST_OUT;
			end
			ST_ROT2: state_d = ST_OUT;
			ST_DIV:  if (div_done) state_d = ST_OUT;
			ST_OUT:  if (rsp_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall = (state_q != ST_IDLE);
		ds_re = (state_q == ST_RDB) || (state_q == ST_RDC);
		ds_raddr = (state_q == ST_RDB) ? dp_q[SIDX_BITS-1:0] - 2'd2
			: dp_q[SIDX_BITS-1:0] - 2'd3;
		rs_re = (state_q == ST_RDB);
		cm_re = (state_q == ST_RDB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dp_q        <= '0;
			rp_q        <= '0;
			free_q      <= '0;
			top_q       <= '0;
			br_q        <= 1'b0;
			used_q      <= 1'b0;
			err_q       <= ERR_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXE) begin
				dp_q   <= ex_dp;
				rp_q   <= ex_rp;
				top_q  <= ex_top;
				br_q   <= ex_br;
				used_q <= ex_used;
				err_q  <= err_c;
				if (ex_free_inc)
					free_q <= free_q + 1'b1;
			end else if (state_q == ST_ROT2) begin
				top_q <= c;
			end else if (state_q == ST_DIV && div_done) begin
				top_q <= div_res;
				dp_q  <= dp_q - 1'b1;
			end
			if (state_q == ST_OUT && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			mode_q <= cmd.mode;
			imm_q  <= cmd.inline_cell;
		end
		if (state_q == ST_RDC)
			b_q <= ds_rd_q;
		if (state_q == ST_OUT && rsp_free) begin
			rsp_q.top_value    <= top_q;
			rsp_q.data_depth   <= dp_q;
			rsp_q.return_depth <= rp_q;
			rsp_q.take_branch  <= br_q;
			rsp_q.used_inline  <= used_q;
			rsp_q.error_code   <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ds_re)
			ds_rd_q <= ds_mem[ds_raddr];
		if (ds_we)
			ds_mem[ds_waddr] <= ds_wdata;
	end

	always_ff @(posedge clk) begin
		if (rs_re)
			rs_rd_q <= rs_mem[rp_q[RIDX_BITS-1:0] - 1'b1];
		if (rs_we)
			rs_mem[rp_q[RIDX_BITS-1:0]] <= a;
	end

	always_ff @(posedge clk) begin
		if (cm_re)
			cm_rd_q <= cm_mem[top_q[MADDR_BITS-1:0]];
		if (cm_we)
			cm_mem[cm_waddr] <= cm_wdata;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_top_zero_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dp_q == '0 |-> top_q == '0)
		else $error("top cell not zero on empty stack");

	a_depth_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		dp_q <= SP_BITS'(STACK_DEPTH) && rp_q <= SP_BITS'(RSTACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_err_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error_code != ERR_OK |-> !rsp.take_branch && !rsp.used_inline)
		else $error("branch flag set on failed step");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider running outside divide state");

	a_err_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXE && err_c != ERR_OK |=> $stable(dp_q) && $stable(rp_q)
			&& $stable(free_q))
		else $error("failed step changed pointers");

endmodule

`default_nettype wire

// ===== design/fsc_div.sv =====
// fsc_div: unsigned restoring divider, one quotient bit per cycle
// takes magnitudes from forth_stack_core; needs fsc_pkg for the cell width
`default_nettype none

module fsc_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [fsc_pkg::CELL_BITS-1:0] dividend,
	input  wire logic [fsc_pkg::CELL_BITS-1:0] divisor,
	output logic                              busy,
	output logic                              done,
	output logic [fsc_pkg::CELL_BITS-1:0]     quotient,
	output logic [fsc_pkg::CELL_BITS-1:0]     remainder
);
	import fsc_pkg::*;

	logic                 busy_q, done_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic [CELL_BITS-1:0] quo_q, rem_q, dvs_q;
	logic [CELL_BITS:0]   trial;

	assign trial = {rem_q, quo_q[CELL_BITS-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_BITS'(CELL_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[CELL_BITS]) begin
				rem_q <= trial[CELL_BITS-1:0];
				quo_q <= {quo_q[CELL_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CELL_BITS-2:0], quo_q[CELL_BITS-1]};
				quo_q <= {quo_q[CELL_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== tb/sv/fsc_checker.sv =====
// fsc_checker: watches the cmd and rsp channels of forth_stack_core,
// predicts each response from its own copy of the stacks and memory, compares
// depends on fsc_pkg
`default_nettype none

module fsc_checker
	import fsc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	input  wire logic  cmd_stall,
	input  wire cmd_t  cmd,
	input  wire logic  rsp_valid,
	input  wire logic  rsp_stall,
	input  wire rsp_t  rsp,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CELL_BITS-1:0] dstk [STACK_DEPTH];
	logic [CELL_BITS-1:0] rstk [RSTACK_DEPTH];
	logic [CELL_BITS-1:0] mem [MEM_CELLS];
	int unsigned dsp, rsp_n, here_idx;
	rsp_t expected_rsps[$];

	assign pending = expected_rsps.size();

	function automatic bit bad_addr(logic [CELL_BITS-1:0] v);
		return v[CELL_BITS-1] || v >= MEM_CELLS;
	endfunction

	function automatic rsp_t execute_prim(cmd_t c);
		rsp_t o;
		int unsigned need;
		logic [CELL_BITS-1:0] a, b, cc, r, ma, mb;
		err_t err;
		bit br, used;
		need = 0; err = ERR_OK; br = 0; used = 0; a = '0; b = '0; cc = '0; r = '0;
		case (c.mode)
			MODE_DUP, MODE_DROP, MODE_TOR, MODE_ZEQ, MODE_FETCH, MODE_COMMA,
			MODE_ZBRANCH: need = 1;
			MODE_SWAP, MODE_OVER, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD,
			MODE_EQ, MODE_LT, MODE_GT, MODE_STORE: need = 2;
			MODE_ROT: need = 3;
			default: need = 0;
		endcase
		if (dsp >= 1) a = dstk[dsp-1];
		if (dsp >= 2) b = dstk[dsp-2];
		if (dsp >= 3) cc = dstk[dsp-3];
		if (dsp < need)
			err = ERR_DUNDER;
		else if ((c.mode == MODE_RFROM || c.mode == MODE_RFETCH) && rsp_n == 0)
			err = ERR_RUNDER;
		else if ((c.mode inside {MODE_DUP, MODE_OVER, MODE_RFROM, MODE_RFETCH,
				MODE_HERE, MODE_LIT}) && dsp >= STACK_DEPTH)
			err = ERR_DOVER;
		else if (c.mode == MODE_TOR && rsp_n >= RSTACK_DEPTH)
			err = ERR_ROVER;
		else if ((c.mode == MODE_DIV || c.mode == MODE_MOD) && a == 0)
			err = ERR_DIVZ;
		else if ((c.mode == MODE_FETCH || c.mode == MODE_STORE) && bad_addr(a))
			err = ERR_ADDR;
		else if (c.mode == MODE_COMMA && here_idx >= MEM_CELLS)
			err = ERR_ADDR;
		if (err == ERR_OK) begin
			case (c.mode)
				MODE_DUP: begin dstk[dsp] = a; dsp++; end
				MODE_DROP: dsp--;
				MODE_SWAP: begin dstk[dsp-1] = b; dstk[dsp-2] = a; end
				MODE_OVER: begin dstk[dsp] = b; dsp++; end
				MODE_ROT: begin dstk[dsp-3] = b; dstk[dsp-2] = a; dstk[dsp-1] = cc; end
				MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_EQ, MODE_LT,
				MODE_GT: begin
					mb = b[CELL_BITS-1] ? -b : b;
					ma = a[CELL_BITS-1] ? -a : a;
					case (c.mode)
						MODE_ADD: r = b + a;
						MODE_SUB: r = b - a;
						MODE_MUL: r = b * a;
						MODE_DIV: begin
							r = mb / ma;
							if (b[CELL_BITS-1] != a[CELL_BITS-1]) r = -r;
						end
						MODE_MOD: begin
							r = mb % ma;
							if (b[CELL_BITS-1]) r = -r;
						end
						MODE_EQ: r = (a == b) ? '1 : '0;
						MODE_LT: r = ($signed(b) < $signed(a)) ? '1 : '0;
						default: r = ($signed(b) > $signed(a)) ? '1 : '0;
					endcase
					dstk[dsp-2] = r; dsp--;
				end
				MODE_TOR: begin rstk[rsp_n] = a; rsp_n++; dsp--; end
				MODE_RFROM: begin rsp_n--; dstk[dsp] = rstk[rsp_n]; dsp++; end
				MODE_RFETCH: begin dstk[dsp] = rstk[rsp_n-1]; dsp++; end
				MODE_ZEQ: dstk[dsp-1] = (a == 0) ? '1 : '0;
				MODE_FETCH: dstk[dsp-1] = mem[a[MADDR_BITS-1:0]];
				MODE_STORE: begin mem[a[MADDR_BITS-1:0]] = b; dsp -= 2; end
				MODE_HERE: begin dstk[dsp] = here_idx; dsp++; end
				MODE_COMMA: begin mem[here_idx] = a; here_idx++; dsp--; end
				MODE_LIT: begin dstk[dsp] = c.inline_cell; dsp++; used = 1; end
				MODE_BRANCH: br = 1;
				MODE_ZBRANCH: begin
					dsp--;
					if (a == 0) br = 1; else used = 1;
				end
				default: ;
			endcase
		end
		o.top_value = (dsp > 0) ? dstk[dsp-1] : '0;
		o.data_depth = SP_BITS'(dsp);
		o.return_depth = SP_BITS'(rsp_n);
		o.take_branch = br;
		o.used_inline = used;
		o.error_code = err;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		dsp = 0; rsp_n = 0; here_idx = 0;
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				expected_rsps.push_back(execute_prim(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected item", rsp, 0);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.top_value !== want.top_value)
						report_mismatch("top_value", rsp.top_value, want.top_value);
					if (rsp.data_depth !== want.data_depth)
						report_mismatch("data_depth", rsp.data_depth, want.data_depth);
					if (rsp.return_depth !== want.return_depth)
						report_mismatch("return_depth", rsp.return_depth, want.return_depth);
					if (rsp.take_branch !== want.take_branch)
						report_mismatch("take_branch", rsp.take_branch, want.take_branch);
					if (rsp.used_inline !== want.used_inline)
						report_mismatch("used_inline", rsp.used_inline, want.used_inline);
					if (rsp.error_code !== want.error_code)
						report_mismatch("error_code", rsp.error_code, want.error_code);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_forth_stack_core.sv =====
// tb_forth_stack_core: drives directed and random primitives into
// forth_stack_core, stalls the response side, gives the verdict
// depends on fsc_pkg, forth_stack_core and fsc_checker
`default_nettype none

module tb_forth_stack_core;
	import fsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int fail_count, pending;
	bit stim_done = 0;
	// addresses known to hold a written cell
	bit written[MEM_CELLS];
	int unsigned here_model = 0;

	always #6 clk = ~clk;

	forth_stack_core dut (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	fsc_checker chk (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	// offer one item and wait until it is taken
	task automatic send_item(mode_t m, logic [CELL_BITS-1:0] v);
		cmd_valid <= 1'b1;
		cmd <= '{mode: m, inline_cell: v};
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	task automatic pause_sender();
		int unsigned g;
		g = $urandom_range(1, 6);
		cmd_valid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	// track which memory cells get written, from the checker's view of the stack
	// sampled at the falling edge ahead of the accepting edge, before the checker moves on
	always @(negedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (cmd.mode == MODE_STORE && chk.dsp >= 2 && !chk.bad_addr(chk.dstk[chk.dsp-1]))
				written[chk.dstk[chk.dsp-1][MADDR_BITS-1:0]] = 1;
			if (cmd.mode == MODE_COMMA && chk.dsp >= 1 && chk.here_idx < MEM_CELLS)
				written[chk.here_idx] = 1;
		end
	end

	function automatic logic [CELL_BITS-1:0] rand_cell();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// pick a random primitive, avoiding a fetch of an unwritten cell
	task automatic send_random();
		mode_t m;
		logic [CELL_BITS-1:0] v;
		int unsigned addr;
		int unsigned pick;
		v = rand_cell();
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// push an address then fetch or store through it
			addr = (pick < 6) ? $urandom_range(0, 15) : $urandom_range(0, MEM_CELLS-1);
			if ($urandom_range(0, 9) == 0) addr = $urandom_range(0, 1) ? MEM_CELLS : -1;
			send_item(MODE_LIT, addr);
			if ($urandom_range(0, 1) || addr >= MEM_CELLS)
				m = MODE_STORE;
			else
				m = written[addr] ? MODE_FETCH : MODE_STORE;
		end else if (pick < 30) begin
			m = MODE_LIT;
		end else begin
			m = mode_t'($urandom_range(0, 31));
			if (m == MODE_FETCH) begin
				if (chk.dsp >= 1 && !chk.bad_addr(chk.dstk[chk.dsp-1])
						&& !written[chk.dstk[chk.dsp-1][MADDR_BITS-1:0]])
					m = MODE_DUP;
			end
		end
		send_item(m, v);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: underflows on empty stacks, then divide, memory, return stack and branch primitives with extremes
		send_item(MODE_DROP, '0);
		send_item(MODE_RFROM, '0);
		send_item(MODE_BRANCH, 32'h8000_0000);
		send_item(mode_t'(5'd31), '0);
		send_item(MODE_LIT, 32'h8000_0000);
		send_item(MODE_LIT, 32'hffff_ffff);
		send_item(MODE_DIV, '0);
		send_item(MODE_LIT, 32'h8000_0000);
		send_item(MODE_LIT, 32'hffff_ffff);
		send_item(MODE_MOD, '0);
		send_item(MODE_LIT, 32'h0);
		send_item(MODE_DIV, '0);
		send_item(MODE_LIT, 32'h7fff_ffff);
		send_item(MODE_FETCH, '0);
		send_item(MODE_LIT, 32'h0);
		send_item(MODE_STORE, '0);
		send_item(MODE_HERE, '0);
		send_item(MODE_COMMA, '0);
		send_item(MODE_TOR, '0);
		send_item(MODE_RFETCH, '0);
		send_item(MODE_ZBRANCH, 32'h1234);
		send_item(MODE_LIT, 32'h5);
		send_item(MODE_ZBRANCH, 32'h55);
		// fill the data stack to overflow
		repeat (34) send_item(MODE_LIT, $urandom);
		repeat (34) send_item(MODE_TOR, '0);
		repeat (30) send_item(MODE_DROP, '0);
		// fill memory with comma until here is full
		repeat (MEM_CELLS + 2) begin
			send_item(MODE_LIT, $urandom);
			send_item(MODE_COMMA, '0);
		end
		send_item(MODE_LIT, 32'h1);
		send_item(MODE_COMMA, '0);
		// random bursts
		repeat (1250) begin
			if ($urandom_range(0, 7) == 0) pause_sender();
			send_random();
			if (chk.dsp > 28 && $urandom_range(0, 1)) send_item(MODE_DROP, '0);
			if (chk.rsp_n > 28 && $urandom_range(0, 1)) send_item(MODE_RFROM, '0);
		end
		cmd_valid <= 1'b0;
		// let the checker take in the last item before the end is judged
		@(posedge clk);
		stim_done = 1;
	end

	// receiver stall pattern with one long hold-off early on
	initial begin
		int unsigned k;
		@(posedge arst_n);
		repeat (200) @(posedge clk);
		rsp_stall <= 1'b1;
		for (k = 0; k < 150; k++) @(posedge clk);
		forever begin
			@(posedge clk);
			case ($urandom_range(0, 3))
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				default: rsp_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// watchdog and verdict
	initial begin
		int unsigned idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("forth_stack_core regression: fail");
				$finish;
			end
			if (stim_done && pending == 0) begin
				repeat (50) @(posedge clk);
				if (fail_count == 0)
					$display("forth_stack_core regression: pass");
				else
					$display("forth_stack_core regression: fail");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
